// ===== design/nlfr_pkg.sv =====
// shared types and constants of the nibble link frame receiver
// no dependencies; used by nlfr_sym_detect, nlfr_framer and the top level
package nlfr_pkg;

  // framing codes on the line
  localparam logic [3:0] CODE_START_BYTE = 4'hB;
  localparam logic [3:0] CODE_END_BYTE   = 4'h9;
  localparam logic [3:0] CODE_START_SUM  = 4'hA;
  localparam logic [3:0] CODE_END_SUM    = 4'h8;

  localparam int unsigned  TIMEOUT_W     = 16;
  localparam logic [15:0]  TIMEOUT_RESET = 16'd80;
  localparam int unsigned  DATA_NIBBLES  = 3;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_MISMATCH    = 3'd1,
    ST_NO_SUM      = 3'd2,
    ST_ORPHAN_END  = 3'd3,
    ST_WRONG_COUNT = 3'd4
  } status_e;

  // symbol handed from the line detector to the framer
  typedef struct packed {
    logic       valid;
    logic [3:0] code;
  } sym_t;

  // frame report handed from the framer to the result register
  typedef struct packed {
    logic       valid;
    status_e    status;
    logic [7:0] data_byte;
    logic       send_nak;
  } result_t;

endpackage

// ===== design/nlfr_sym_detect.sv =====
// line sample tracker: complement match, skip flag and resync timeout
// depends on nlfr_pkg
module nlfr_sym_detect #(
  parameter int unsigned TICK_COUNTER_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic [3:0]                    sample_i,
  input  logic [nlfr_pkg::TIMEOUT_W-1:0] timeout_i,
  output nlfr_pkg::sym_t                sym_o
);

  localparam int unsigned CMP_W = (TICK_COUNTER_WIDTH > nlfr_pkg::TIMEOUT_W) ?
                                  TICK_COUNTER_WIDTH : nlfr_pkg::TIMEOUT_W;

  logic [3:0]                    held_q, held_d;
  logic [TICK_COUNTER_WIDTH-1:0] ticks_q, ticks_d, elapsed;
  logic                          skip_q, skip_d;
  logic                          timeout_hit, match;

  always_comb begin
    elapsed     = (ticks_q != '1) ? ticks_q + 1'b1 : ticks_q;
    timeout_hit = CMP_W'(elapsed) >= CMP_W'(timeout_i);
    match       = (~sample_i) == held_q;
    held_d      = held_q;
    ticks_d     = ticks_q;
    skip_d      = skip_q;
    sym_o.valid = 1'b0;
    sym_o.code  = held_q;
    if (en_i) begin
      held_d = sample_i;
      if (timeout_hit) begin
        // resync: take the sample as reference, nothing else
        ticks_d = '0;
        skip_d  = 1'b0;
      end else begin
        ticks_d = match ? '0 : elapsed;
        if (match) begin
          skip_d      = ~skip_q;
          sym_o.valid = ~skip_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= '0;
      ticks_q <= '0;
      skip_q  <= 1'b0;
    end else begin
      held_q  <= held_d;
      ticks_q <= ticks_d;
      skip_q  <= skip_d;
    end
  end

endmodule

// ===== design/nlfr_framer.sv =====
// frame and checksum store with byte rebuild and status decision
// depends on nlfr_pkg
module nlfr_framer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  nlfr_pkg::sym_t    sym_i,
  output nlfr_pkg::result_t result_o
);

  logic       frame_open_q, frame_open_d, frame_closed_q, frame_closed_d;
  logic       sum_open_q, sum_open_d, sum_closed_q, sum_closed_d;
  logic [2:0] count_q, count_d;
  logic       sum_present_q, sum_present_d;
  logic [3:0] sum_q, sum_d;
  logic [3:0] nib_q [nlfr_pkg::DATA_NIBBLES];
  logic [3:0] nib_d [nlfr_pkg::DATA_NIBBLES];
  logic [7:0] rebuilt;
  logic [3:0] want;
  logic [3:0] c;

  always_comb begin
    rebuilt = {nib_q[0][2:0], 5'b0} | {2'b0, nib_q[1], 2'b0} | {5'b0, nib_q[2][3:1]};
    want    = 4'd8 - 4'($countones(rebuilt));
  end

  always_comb begin
    c              = sym_i.code;
    frame_open_d   = frame_open_q;
    frame_closed_d = frame_closed_q;
    sum_open_d     = sum_open_q;
    sum_closed_d   = sum_closed_q;
    count_d        = count_q;
    sum_present_d  = sum_present_q;
    sum_d          = sum_q;
    nib_d          = nib_q;
    result_o.valid     = 1'b0;
    result_o.status    = nlfr_pkg::ST_OK;
    result_o.data_byte = '0;
    result_o.send_nak  = 1'b0;
    if (sym_i.valid) begin
      if (c == nlfr_pkg::CODE_END_BYTE) frame_closed_d = 1'b1;
      if (frame_open_q && !frame_closed_d) begin
        if (count_q < 3'd3) nib_d[count_q[1:0]] = c;
        if (count_q < 3'd4) count_d = count_q + 3'd1;
      end
      if (c == nlfr_pkg::CODE_START_BYTE) begin
        frame_open_d   = 1'b1;
        frame_closed_d = 1'b0;
        count_d        = '0;
        sum_present_d  = 1'b0;
      end
      if (c == nlfr_pkg::CODE_END_SUM) begin
        sum_closed_d = 1'b1;
        sum_open_d   = 1'b0;
      end
      // only the first checksum nibble after a clear is kept
      if (sum_open_d && !sum_closed_d && !sum_present_d) begin
        sum_d         = c;
        sum_present_d = 1'b1;
      end
      if (c == nlfr_pkg::CODE_START_SUM) begin
        sum_open_d   = 1'b1;
        sum_closed_d = 1'b0;
      end
      if (c == nlfr_pkg::CODE_END_SUM) begin
        result_o.valid = 1'b1;
        priority if (!(frame_open_d && frame_closed_d)) begin
          result_o.status = nlfr_pkg::ST_ORPHAN_END;
        end else if (count_d != 3'd3) begin
          result_o.status = nlfr_pkg::ST_WRONG_COUNT;
        end else if (!sum_present_d) begin
          result_o.status = nlfr_pkg::ST_NO_SUM;
        end else if (sum_d == want) begin
          result_o.status    = nlfr_pkg::ST_OK;
          result_o.data_byte = rebuilt;
        end else begin
          result_o.status    = nlfr_pkg::ST_MISMATCH;
          result_o.data_byte = rebuilt;
        end
        result_o.send_nak = result_o.status != nlfr_pkg::ST_OK;
        count_d       = '0;
        sum_present_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_open_q   <= 1'b0;
      frame_closed_q <= 1'b0;
      sum_open_q     <= 1'b0;
      sum_closed_q   <= 1'b0;
      count_q        <= '0;
      sum_present_q  <= 1'b0;
    end else begin
      frame_open_q   <= frame_open_d;
      frame_closed_q <= frame_closed_d;
      sum_open_q     <= sum_open_d;
      sum_closed_q   <= sum_closed_d;
      count_q        <= count_d;
      sum_present_q  <= sum_present_d;
    end
  end

  // payload stores, read only after written
  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    nib_q <= nib_d;
  end

endmodule

// ===== design/nibble_link_frame_receiver_core.sv =====
// nibble link frame receiver: top level with input and result registers
// depends on nlfr_pkg, nlfr_sym_detect and nlfr_framer
// a taken sample word waits in the input register until the result register is free
// throughput: one sample word per cycle; intake stops only while a result word is stalled
// reset (rst_ni, async, active low) clears the line tracker, frame flags and valids,
// and loads timeout_ticks with 80; no clearing pass is needed
module nibble_link_frame_receiver_core #(
  parameter int unsigned TICK_COUNTER_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // sample stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [3:0] port_nibble, [7:4] zero
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] data_byte
  output logic [3:0]  m_axis_tuser,   // [2:0] status, [3] send_nak
  // timeout_ticks register write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  logic                   in_valid_q;
  logic [3:0]             in_sample_q;
  logic [15:0]            timeout_q;
  logic                   advance;
  logic                   out_valid_q, out_valid_d;
  nlfr_pkg::status_e      out_status_q;
  logic [7:0]             out_byte_q;
  logic                   out_nak_q;
  nlfr_pkg::sym_t         sym;
  nlfr_pkg::result_t      result;

  // the stored sample is processed once the result register can take its outcome
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= nlfr_pkg::TIMEOUT_RESET;
    end else if (cfg_valid_i) begin
      timeout_q <= cfg_data_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_sample_q <= s_axis_tdata[3:0];
    end
  end

  nlfr_sym_detect #(
    .TICK_COUNTER_WIDTH(TICK_COUNTER_WIDTH)
  ) u_sym_detect (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .sample_i (in_sample_q),
    .timeout_i(timeout_q),
    .sym_o    (sym)
  );

  nlfr_framer u_framer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sym_i   (sym),
    .result_o(result)
  );

  // result register: loads on every processed sample, drains when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = result.valid;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && result.valid) begin
      out_status_q <= result.status;
      out_byte_q   <= result.data_byte;
      out_nak_q    <= result.send_nak;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tuser  = {out_nak_q, out_status_q};

`ifndef SYNTH
  // nak request follows the status
  a_nak_matches_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_nak_q == (out_status_q != nlfr_pkg::ST_OK)))
    else $error("send_nak disagrees with status");

  // no byte is reported with a framing error
  a_byte_zero_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (out_status_q == nlfr_pkg::ST_NO_SUM ||
     out_status_q == nlfr_pkg::ST_ORPHAN_END || out_status_q == nlfr_pkg::ST_WRONG_COUNT))
    |-> (out_byte_q == 8'd0))
    else $error("byte reported with framing error");

  // a new result only appears after a stored sample was processed
  a_result_from_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(advance))
    else $error("result word without a processed sample");

  // results only on the end checksum code
  a_result_on_end_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result.valid |-> (sym.valid && sym.code == nlfr_pkg::CODE_END_SUM && advance))
    else $error("result outside end checksum symbol");
`endif

endmodule

// ===== verif/tb_nibble_link_frame_receiver_core.sv =====
// self-checking testbench for nibble_link_frame_receiver_core: line sample words in,
// frame report words out, checked against an in-bench line and framing tracker
// depends on nlfr_pkg and the design files under design/
`timescale 1ns / 100ps

module tb_nibble_link_frame_receiver_core;

  // expected frame report, one per end-checksum symbol
  typedef struct packed {
    nlfr_pkg::status_e status;
    logic [7:0]        data_byte;
    logic              send_nak;
  } frame_report_t;

  // checksum section of a generated frame
  typedef enum int {
    SK_NONE,   // no checksum section
    SK_RIGHT,  // right sum
    SK_WRONG,  // wrong sum
    SK_EMPTY,  // checksum section without nibble
    SK_EXTRA   // right sum then extra nibbles
  } sum_kind_e;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;  // [3:0] port_nibble, [7:4] zero
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;           // [7:0] data_byte
  logic [3:0]  m_axis_tuser;           // [2:0] status, [3] send_nak
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i    = 16'h0000;

  nibble_link_frame_receiver_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // 2 ns clock
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // ---------------------------------------------------------------------------
  // bench state
  // ---------------------------------------------------------------------------
  logic [3:0]    line_q[$];      // sample words still to be driven
  frame_report_t report_q[$];    // reports predicted but not yet seen
  int            samples_left;   // words queued and not yet accepted
  int            fault_count;
  bit            calm;           // no idling on either side while set
  bit            sample_taken;   // sample handshake at the last rising edge
  bit            cfg_taken;      // register handshake at the last rising edge
  logic [3:0]    gen_last;       // last sample queued, for choosing separators
  logic [15:0]   gen_timeout;    // timeout in force while a phase is generated

  // predictor copy of the receiver
  logic [15:0]   ln_timeout;
  logic [3:0]    ln_held;
  logic [15:0]   ln_ticks;
  bit            ln_skip;
  bit            fr_open, fr_closed, sum_open, sum_closed, sum_seen;
  logic [3:0]    fr_nib[3];
  logic [2:0]    fr_count;
  logic [3:0]    sum_nib;

  task automatic note_fault(input string msg);
    $display("mismatch: %s", msg);
    fault_count++;
  endtask

  // byte rebuilt from 3+4+3 bits, the three fields overlap by one bit each
  function automatic logic [7:0] frame_byte(input logic [3:0] n0, n1, n2);
    logic [7:0] a, b, c;
    a = {4'h0, n0};
    b = {4'h0, n1};
    c = {4'h0, n2};
    return (a << 5) | (b << 2) | (c >> 1);
  endfunction

  function automatic logic [3:0] zeros_in(input logic [7:0] b);
    return 4'd8 - 4'($countones(b));
  endfunction

  task automatic add_report(input nlfr_pkg::status_e st, input logic [7:0] b);
    frame_report_t r;
    r.status    = st;
    r.data_byte = b;
    r.send_nak  = (st != nlfr_pkg::ST_OK);
    report_q.insert(report_q.size(), r);
  endtask

  // framing of one recognised symbol; the flag order matters, codes are
  // tested before and after the stores are touched
  task automatic frame_symbol(input logic [3:0] c);
    logic [7:0] b;
    if (c == nlfr_pkg::CODE_END_BYTE) fr_closed = 1'b1;
    if (fr_open && !fr_closed) begin
      if (fr_count < 3) fr_nib[fr_count] = c;
      if (fr_count < 4) fr_count++;
    end
    if (c == nlfr_pkg::CODE_START_BYTE) begin
      fr_open   = 1'b1;
      fr_closed = 1'b0;
      fr_count  = 3'd0;
      sum_seen  = 1'b0;
    end
    if (c == nlfr_pkg::CODE_END_SUM) begin
      sum_closed = 1'b1;
      sum_open   = 1'b0;
    end
    if (sum_open && !sum_closed && !sum_seen) begin
      sum_nib  = c;
      sum_seen = 1'b1;
    end
    if (c == nlfr_pkg::CODE_START_SUM) begin
      sum_open   = 1'b1;
      sum_closed = 1'b0;
    end
    if (c == nlfr_pkg::CODE_END_SUM) begin
      if (fr_open && fr_closed) begin
        if (fr_count != 3'd3) begin
          add_report(nlfr_pkg::ST_WRONG_COUNT, 8'h00);
        end else begin
          b = frame_byte(fr_nib[0], fr_nib[1], fr_nib[2]);
          if (!sum_seen) add_report(nlfr_pkg::ST_NO_SUM, 8'h00);
          else if (sum_nib == zeros_in(b)) add_report(nlfr_pkg::ST_OK, b);
          else add_report(nlfr_pkg::ST_MISMATCH, b);
        end
      end else begin
        add_report(nlfr_pkg::ST_ORPHAN_END, 8'h00);
      end
      fr_count = 3'd0;
      sum_seen = 1'b0;
    end
  endtask

  // one line sample: timeout resync, complement match, skip of every second match
  task automatic line_step(input logic [3:0] s);
    logic [15:0] elapsed;
    elapsed = ln_ticks;
    if (elapsed != 16'hFFFF) elapsed++;
    if (elapsed >= ln_timeout) begin
      ln_held  = s;
      ln_ticks = '0;
      ln_skip  = 1'b0;
    end else begin
      ln_ticks = elapsed;
      if ((s ^ 4'hF) == ln_held) begin
        ln_ticks = '0;
        if (ln_skip) begin
          ln_skip = 1'b0;
        end else begin
          ln_skip = 1'b1;
          frame_symbol(ln_held);
        end
      end
      ln_held = s;
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver, sink and monitor
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || sample_taken)) begin
      if (line_q.size() != 0 && (calm || $urandom_range(0, 99) >= 8)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'h0, line_q.pop_front()};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) m_axis_tready <= calm || ($urandom_range(0, 99) >= 8);
  end

  always @(posedge clk_i) begin
    frame_report_t want;
    sample_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
    cfg_taken    <= rst_ni && cfg_valid_i && cfg_ready_o;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) ln_timeout = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) begin
        line_step(s_axis_tdata[3:0]);
        samples_left--;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (report_q.size() == 0) begin
          note_fault($sformatf("report word with none expected, tuser %h tdata %h",
                               m_axis_tuser, m_axis_tdata));
        end else begin
          want = report_q.pop_front();
          if (m_axis_tuser[2:0] !== want.status)
            note_fault($sformatf("status %0d, expected %0d", m_axis_tuser[2:0], want.status));
          if (m_axis_tdata !== want.data_byte)
            note_fault($sformatf("data_byte %h, expected %h", m_axis_tdata, want.data_byte));
          if (m_axis_tuser[3] !== want.send_nak)
            note_fault($sformatf("send_nak %b, expected %b", m_axis_tuser[3], want.send_nak));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic put_sample(input logic [3:0] s);
    line_q.insert(line_q.size(), s);
    samples_left++;
    gen_last = s;
  endtask

  // value, complement, value after a separator that cannot match: exactly one
  // symbol is taken whatever the skip flag holds
  task automatic put_symbol(input logic [3:0] c);
    if (gen_last == (c ^ 4'hF)) put_sample(gen_last ^ 4'h1);
    else put_sample(gen_last);
    put_sample(c);
    put_sample(c ^ 4'hF);
    put_sample(c);
  endtask

  // data nibble, seldom a framing code
  function automatic logic [3:0] data_nib();
    logic [3:0] v;
    v = 4'($urandom_range(0, 15));
    if (v[3:2] == 2'b10 && $urandom_range(0, 3) != 0) v[3] = 1'b0;
    return v;
  endfunction

  task automatic put_frame(input logic [3:0] d0, d1, d2, input int n_data,
                           input sum_kind_e sum_kind);
    logic [3:0] good;
    good = zeros_in(frame_byte(d0, d1, d2));
    put_symbol(nlfr_pkg::CODE_START_BYTE);
    for (int i = 0; i < n_data; i++)
      put_symbol(i == 0 ? d0 : i == 1 ? d1 : i == 2 ? d2 : data_nib());
    put_symbol(nlfr_pkg::CODE_END_BYTE);
    if (sum_kind != SK_NONE) put_symbol(nlfr_pkg::CODE_START_SUM);
    if (sum_kind == SK_RIGHT || sum_kind == SK_EXTRA) put_symbol(good);
    if (sum_kind == SK_WRONG) put_symbol(good + 4'($urandom_range(1, 15)));
    if (sum_kind == SK_EXTRA) begin
      repeat ($urandom_range(1, 3)) put_symbol(4'($urandom_range(0, 15)));
    end
    put_symbol(nlfr_pkg::CODE_END_SUM);
  endtask

  // constant line for longer than the timeout
  task automatic put_silence(input int n);
    repeat (n) put_sample(gen_last);
  endtask

  task automatic put_noise();
    repeat ($urandom_range(1, 6)) put_sample(4'($urandom_range(0, 15)));
  endtask

  task automatic gen_traffic(input int n_samples);
    int goal, pick, nd, n_nib;
    goal = n_samples;
    while (goal > 0) begin
      pick = $urandom_range(0, 99);
      nd   = samples_left;
      if (pick < 50) begin
        put_frame(data_nib(), data_nib(), data_nib(), 3, SK_RIGHT);
      end else if (pick < 60) begin
        put_frame(data_nib(), data_nib(), data_nib(), 3, SK_WRONG);
      end else if (pick < 65) begin
        put_frame(data_nib(), data_nib(), data_nib(), 3, SK_NONE);
      end else if (pick < 68) begin
        put_frame(data_nib(), data_nib(), data_nib(), 3, SK_EMPTY);
      end else if (pick < 75) begin
        // nibble count of 0, 1, 2, 4 or 5
        n_nib = $urandom_range(0, 4);
        if (n_nib >= 3) n_nib++;
        put_frame(data_nib(), data_nib(), data_nib(), n_nib, SK_RIGHT);
      end else if (pick < 80) begin
        put_frame(data_nib(), data_nib(), data_nib(), 3, SK_EXTRA);
      end else if (pick < 85) begin
        put_symbol(nlfr_pkg::CODE_END_SUM);
      end else if (pick < 88) begin
        // frame still open when the end-checksum code comes
        put_symbol(nlfr_pkg::CODE_START_BYTE);
        put_symbol(data_nib());
        put_symbol(nlfr_pkg::CODE_END_SUM);
      end else if (pick < 96 || gen_timeout > 16'd200) begin
        put_noise();
      end else begin
        put_silence(int'(gen_timeout) + $urandom_range(0, 3));
      end
      goal -= samples_left - nd;
    end
  endtask

  // block idle: every word accepted, every report seen, pipeline empty
  task automatic settle();
    do @(negedge clk_i); while (samples_left != 0 || report_q.size() != 0);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_timeout(input logic [15:0] v);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(negedge clk_i); while (!cfg_taken);
    cfg_valid_i <= 1'b0;
    gen_timeout = v;
    repeat (2) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // run
  // ---------------------------------------------------------------------------
  initial begin
    // predictor at its reset state
    ln_timeout = nlfr_pkg::TIMEOUT_RESET;
    ln_held    = 4'h0;
    ln_ticks   = '0;
    ln_skip    = 1'b0;
    fr_open    = 1'b0;
    fr_closed  = 1'b0;
    sum_open   = 1'b0;
    sum_closed = 1'b0;
    sum_seen   = 1'b0;
    fr_count   = 3'd0;
    fr_nib     = '{default: 4'h0};
    sum_nib    = 4'h0;
    gen_last   = 4'h0;
    gen_timeout = nlfr_pkg::TIMEOUT_RESET;
    samples_left = 0;
    fault_count  = 0;
    calm = 1'b0;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part at the reset timeout
    put_symbol(nlfr_pkg::CODE_END_SUM);              // end code before any frame
    put_frame(4'hF, 4'hF, 4'hF, 3, SK_RIGHT);        // byte ff, sum 0
    put_frame(4'h0, 4'h0, 4'h0, 3, SK_RIGHT);        // byte 00, sum 8
    put_frame(4'h5, 4'h3, 4'h6, 3, SK_WRONG);        // checksum mismatch
    put_frame(4'h1, 4'h2, 4'h4, 3, SK_NONE);         // no checksum section
    put_frame(4'h7, 4'h2, 4'h0, 2, SK_RIGHT);        // too few nibbles
    put_frame(4'h3, 4'h6, 4'h1, 5, SK_RIGHT);        // surplus nibbles
    put_frame(4'h2, 4'hC, 4'hD, 3, SK_EXTRA);        // extra checksum nibbles
    put_symbol(nlfr_pkg::CODE_END_SUM);              // completed frame left open: wrong count
    put_symbol(nlfr_pkg::CODE_START_BYTE);
    put_symbol(4'hE);
    put_symbol(nlfr_pkg::CODE_END_SUM);              // frame not closed
    put_silence(83);                                 // resync by timeout
    for (int v = 0; v < 16; v++) put_sample(4'(v));
    put_frame(4'h4, 4'h9, 4'h2, 3, SK_RIGHT);

    // largest timeout, no idling at all
    write_timeout(16'hFFFF);
    calm = 1'b1;
    gen_traffic(280);
    settle();
    calm = 1'b0;

    // smallest timeout: resync on every sample, nothing gets framed
    write_timeout(16'd1);
    gen_traffic(50);

    // one tick too short for the separator gap
    write_timeout(16'd3);
    gen_traffic(110);

    write_timeout(16'($urandom_range(4, 40)));
    gen_traffic(330);

    write_timeout(16'($urandom_range(41, 200)));
    gen_traffic(190);

    write_timeout(nlfr_pkg::TIMEOUT_RESET);
    gen_traffic(240);

    settle();
    repeat (8) @(negedge clk_i);
    if (fault_count == 0) begin
      $display("nibble_link_frame_receiver_core regression: pass");
    end else begin
      $display("nibble_link_frame_receiver_core regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #200000;
    $display("nibble_link_frame_receiver_core regression: fail");
    $finish;
  end

endmodule
